FILE: rtl/mnrt_pkg.sv
package mnrt_pkg;

    localparam int NOTE_W  = 7;
    localparam int MAP_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int DELAY_W = 16;
    localparam int OCTAVE  = 12;
    localparam int CLS_W   = 4;

    localparam logic [BYTE_W-1:0] NONE_CODE = 8'd128;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PAIR  = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;
    localparam logic [1:0] MODE_XLAT  = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NOTE_W-1:0] source_note;
        logic [NOTE_W-1:0] target_note;
        logic [BYTE_W-1:0] status_byte;
        logic [BYTE_W-1:0] note_byte;
        logic [BYTE_W-1:0] velocity_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  status_out;
        logic [BYTE_W-1:0]  mapped_note;
        logic [BYTE_W-1:0]  velocity_out;
        logic [DELAY_W-1:0] delay_out;
        logic               range_error;
    } t_out_item;

endpackage

FILE: rtl/mnrt_alu.sv
module mnrt_alu import mnrt_pkg::*; #(
    parameter int W     = 9,
    parameter int LIMIT = 128
) (
    input  logic         i_sub,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_sum,
    output logic         o_in_range
);

    logic [W-1:0] b_op;

    assign b_op       = i_sub ? ~i_b : i_b;
    assign o_sum      = i_a + b_op + W'(i_sub);
    assign o_in_range = !o_sum[W-1] && (o_sum < W'(LIMIT));

endmodule

FILE: rtl/midi_note_remap_table.sv
// Clear and store-pair items complete without leaving the idle state, so the block stays ready.
// A translate item reads the table and moves to state S_TRO, which fills the output register
// when the output side is free, then returns to idle; a stalled result delays the next item.
// An octave fill walks all NOTE_COUNT entries: S_FJ skips an empty entry; for a mapped one,
// S_FJ reads it, S_FJW forms its offset and S_FI visits each entry of the same pitch class.
// Reset marks every entry as unmapped at once and clears the delay register.
module midi_note_remap_table import mnrt_pkg::*; #(
    parameter int NOTE_COUNT = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [DELAY_W-1:0]   i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int AW = $clog2(NOTE_COUNT);
    localparam int SW = AW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FJ   = 3'd1;
    localparam logic [2:0] S_FJW  = 3'd2;
    localparam logic [2:0] S_FI   = 3'd3;
    localparam logic [2:0] S_TRO  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [NOTE_COUNT-1:0] r_vld;
    logic [MAP_W-1:0]      r_mem [NOTE_COUNT];
    logic [MAP_W-1:0]      r_rdata;
    logic                  r_rvld;
    logic [DELAY_W-1:0]    r_delay;
    logic [AW-1:0]         r_j, n_j;
    logic [CLS_W-1:0]      r_jcls, n_jcls;
    logic [AW:0]           r_i, n_i;
    logic [SW-1:0]         r_ofs, n_ofs;
    logic [BYTE_W-1:0]     r_status, r_vel;
    logic                  r_rerr;
    logic                  r_ovalid, n_ovalid;
    t_out_item             r_out, n_out;

    logic                  in_acc;
    logic                  clr;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [MAP_W-1:0]      mem_wdata;
    logic                  alu_sub;
    logic [SW-1:0]         alu_a, alu_b, alu_sum;
    logic                  alu_ok;
    logic                  last_j;
    logic [CLS_W-1:0]      cls_inc;
    logic [AW:0]           i_step;
    logic                  out_free;

    mnrt_alu #(
        .W     (SW),
        .LIMIT (NOTE_COUNT)
    ) u_alu (
        .i_sub      (alu_sub),
        .i_a        (alu_a),
        .i_b        (alu_b),
        .o_sum      (alu_sum),
        .o_in_range (alu_ok)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign last_j      = (r_j == AW'(NOTE_COUNT - 1));
    assign cls_inc     = (r_jcls == CLS_W'(OCTAVE - 1)) ? '0 : r_jcls + CLS_W'(1);
    assign i_step      = r_i + (AW+1)'(OCTAVE);

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_jcls    = r_jcls;
        n_i       = r_i;
        n_ofs     = r_ofs;
        n_ovalid  = r_ovalid && i_out_stall;
        n_out     = r_out;
        clr       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = AW'(i_in_data.source_note);
        mem_wdata = MAP_W'(i_in_data.target_note);
        mem_re    = 1'b0;
        mem_raddr = AW'(i_in_data.note_byte);
        alu_sub   = 1'b0;
        alu_a     = '0;
        alu_b     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.mode)
                        MODE_CLEAR: clr = 1'b1;
                        MODE_PAIR:  mem_we = 1'b1;
                        MODE_FILL: begin
                            n_j     = '0;
                            n_jcls  = '0;
                            n_state = S_FJ;
                        end
                        MODE_XLAT: begin
                            mem_re  = 1'b1;
                            n_state = S_TRO;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FJ: begin
                if (r_vld[r_j]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j;
                    n_state   = S_FJW;
                end else begin
                    n_j     = r_j + AW'(1);
                    n_jcls  = cls_inc;
                    n_state = last_j ? S_IDLE : S_FJ;
                end
            end
            S_FJW: begin
                alu_sub = 1'b1;
                alu_a   = SW'(r_rdata);
                alu_b   = SW'(r_j);
                n_ofs   = alu_sum;
                n_i     = (AW+1)'(r_jcls);
                n_state = S_FI;
            end
            S_FI: begin
                alu_a     = r_ofs;
                alu_b     = SW'(r_i);
                mem_waddr = r_i[AW-1:0];
                mem_wdata = MAP_W'(alu_sum);
                mem_we    = !r_vld[r_i[AW-1:0]] && alu_ok;
                n_i       = i_step;
                if (i_step >= (AW+1)'(NOTE_COUNT)) begin
                    n_j     = r_j + AW'(1);
                    n_jcls  = cls_inc;
                    n_state = last_j ? S_IDLE : S_FJ;
                end
            end
            S_TRO: begin
                if (out_free) begin
                    n_ovalid           = 1'b1;
                    n_out.status_out   = r_status;
                    n_out.velocity_out = r_vel;
                    n_out.delay_out    = r_delay;
                    n_out.range_error  = r_rerr;
                    n_out.mapped_note  = (r_rerr || !r_rvld) ? NONE_CODE
                                                             : BYTE_W'(r_rdata);
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_delay  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_delay <= i_cfg_wr_data;
            end
            if (clr) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
            r_rvld  <= r_vld[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_jcls <= n_jcls;
        r_i    <= n_i;
        r_ofs  <= n_ofs;
        r_out  <= n_out;
        if (in_acc) begin
            r_status <= i_in_data.status_byte;
            r_vel    <= i_in_data.velocity_byte;
            r_rerr   <= (i_in_data.note_byte >= BYTE_W'(NOTE_COUNT));
        end
    end

    a_out_from_xlat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_TRO)
        else $error("result appeared without a translate transfer");

    a_i_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FI |-> !r_i[AW])
        else $error("fill index left the table");

    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FJ || r_state == S_FJW) |-> r_jcls < CLS_W'(OCTAVE))
        else $error("pitch class counter out of range");

    a_err_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.range_error) |-> r_out.mapped_note == NONE_CODE)
        else $error("range error without the none code");

endmodule
